// File: rtl/assert_macros.svh
// Assertion helpers shared by the touch calibration RTL.
// Every check is clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that holds at every clock edge outside reset.
`define TPAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be true at a clock edge outside reset.
`define TPAC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/tpac_pkg.sv
// Shared constants for the touch point average and calibration block.
// No dependencies; imported by touch_point_average_calibrate.
`timescale 1ns / 1ps

package tpac_pkg;

    // Stream payload widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 1;

    // Field widths
    localparam int FINGER_W = 4;
    localparam int EVENT_W  = 4;
    localparam int RAW_W    = 12;
    localparam int SCREEN_W = 16;

    // Configuration port
    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 4;

    localparam logic [1:0] REG_OFFSET_H = 2'd0;
    localparam logic [1:0] REG_RATIO_H  = 2'd1;
    localparam logic [1:0] REG_OFFSET_V = 2'd2;
    localparam logic [1:0] REG_RATIO_V  = 2'd3;

    // Point status codes and limits
    localparam logic [EVENT_W-1:0]  EVENT_CONTACT = 4'h8;
    localparam logic [FINGER_W-1:0] FINGER_LIMIT  = 4'd5;

    // Divider and calibration arithmetic
    localparam int DIV_W  = 32;   // divider dividend, divisor and quotient width
    localparam int STEP_W = 6;    // holds DIV_W
    localparam int FRAC_W = 16;   // 16.16 fixed point
    localparam int NUM_W  = 34;   // (avg << 16) - offset, signed

    localparam logic [DIV_W-1:0] SAT_POS_MAX = 32'd32767;
    localparam logic [DIV_W-1:0] SAT_NEG_MAG = 32'd32768;

endpackage

// File: rtl/touch_point_average_calibrate.sv
// Touch point averaging and linear 16.16 calibration, top level.
// Depends on tpac_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one point record per item; contact records (event nibble 8, at most
// MAX_POINTS per scan) add raw X/Y into running sums. A record that is not
// the last of a scan leaves the input ready for the next record. The last
// record yields one result item: not pressed (zeros), or else the calibrated
// point. Here SW = 12 + clog2(MAX_POINTS+1); an axis whose ratio is zero
// skips its calibration divide. All divides run one quotient bit per cycle
// on a single shared restoring divider: the axis average (SW steps) and then
// ((avg << 16) - offset) / ratio (32 steps), per axis. The input is not ready
// while the divider works; a finished result waits in the output register and
// the next scan can be taken meanwhile.
module touch_point_average_calibrate #(
    parameter int MAX_POINTS = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [3:0] finger_count, [7:4] event_nibble, [19:8] raw_vertical,
    // [31:20] raw_horizontal
    input  logic [tpac_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,    // last_record
    // Result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] screen_horizontal, [31:16] screen_vertical
    output logic [tpac_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] pressed
    output logic [tpac_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    // Configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tpac_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tpac_pkg::CFG_W-1:0]        pwdata,
    output logic [tpac_pkg::CFG_W-1:0]        prdata,
    output logic                              pready
);
    import tpac_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = RAW_W + CNT_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_AVG   = 7'b0000100,
        S_PREP  = 7'b0001000,
        S_CAL   = 7'b0010000,
        S_SAT   = 7'b0100000,
        S_LOAD  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [CFG_W-1:0] offset_h_reg, ratio_h_reg, offset_v_reg, ratio_v_reg;

    // Scan accumulation
    logic [SUM_W-1:0] sum_h_reg, sum_h_next, sum_v_reg, sum_v_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Shared divider
    logic [DIV_W-1:0]  rem_reg, rem_next, quo_reg, quo_next, dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    logic              axis_reg, axis_next;

    // Pending result
    logic                pressed_reg, pressed_next;
    logic [SCREEN_W-1:0] res_h_reg, res_h_next, res_v_reg, res_v_next;

    // Output register
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [OUT_USER_W-1:0] m_user_reg, m_user_next;

    // Input fields
    logic [FINGER_W-1:0] finger_count;
    logic [EVENT_W-1:0]  event_nibble;
    logic [RAW_W-1:0]    raw_vertical, raw_horizontal;

    assign finger_count   = s_axis_tdata[3:0];
    assign event_nibble   = s_axis_tdata[7:4];
    assign raw_vertical   = s_axis_tdata[19:8];
    assign raw_horizontal = s_axis_tdata[31:20];

    logic in_fire, contact, fingers_ok;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign contact       = (event_nibble == EVENT_CONTACT) &&
                           (count_reg < CNT_W'(MAX_POINTS));
    assign fingers_ok    = (finger_count != '0) && (finger_count <= FINGER_LIMIT);

    // Per-axis selection
    logic [SUM_W-1:0] sum_sel;
    logic [CFG_W-1:0] offset_sel, ratio_sel;
    assign sum_sel    = axis_reg ? sum_v_reg    : sum_h_reg;
    assign offset_sel = axis_reg ? offset_v_reg : offset_h_reg;
    assign ratio_sel  = axis_reg ? ratio_v_reg  : ratio_h_reg;

    // One restoring divide step
    logic [DIV_W:0]   rem_shift;
    logic             fits;
    logic [DIV_W:0]   rem_diff;
    logic [DIV_W-1:0] rem_step, quo_step;
    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign fits      = (rem_shift >= {1'b0, dvs_reg});
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign rem_step  = fits ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
    assign quo_step  = {quo_reg[DIV_W-2:0], fits};

    // Calibration numerator and operand magnitudes
    logic [NUM_W-1:0] avg_ext, off_ext, num, num_neg;
    logic [DIV_W-1:0] num_mag, ratio_mag;
    assign avg_ext   = {{(NUM_W-RAW_W-FRAC_W){1'b0}}, quo_reg[RAW_W-1:0], {FRAC_W{1'b0}}};
    assign off_ext   = {{(NUM_W-CFG_W){offset_sel[CFG_W-1]}}, offset_sel};
    assign num       = avg_ext - off_ext;
    assign num_neg   = -num;
    assign num_mag   = num[NUM_W-1] ? num_neg[DIV_W-1:0] : num[DIV_W-1:0];
    assign ratio_mag = ratio_sel[CFG_W-1] ? -ratio_sel : ratio_sel;

    // Signed saturation of the quotient
    logic [DIV_W-1:0]    quo_neg;
    logic [SCREEN_W-1:0] sat_val;
    assign quo_neg = -quo_reg;
    always_comb
    begin
        if (neg_reg)
            sat_val = (quo_reg > SAT_NEG_MAG) ? SAT_NEG_MAG[SCREEN_W-1:0]
                                              : quo_neg[SCREEN_W-1:0];
        else
            sat_val = (quo_reg > SAT_POS_MAX) ? SAT_POS_MAX[SCREEN_W-1:0]
                                              : quo_reg[SCREEN_W-1:0];
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next   = state_reg;
        sum_h_next   = sum_h_reg;
        sum_v_next   = sum_v_reg;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dvs_next     = dvs_reg;
        step_next    = step_reg;
        neg_next     = neg_reg;
        axis_next    = axis_reg;
        pressed_next = pressed_reg;
        res_h_next   = res_h_reg;
        res_v_next   = res_v_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (contact)
                    begin
                        sum_h_next = sum_h_reg + {{(SUM_W-RAW_W){1'b0}}, raw_horizontal};
                        sum_v_next = sum_v_reg + {{(SUM_W-RAW_W){1'b0}}, raw_vertical};
                        count_next = count_reg + 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        if (fingers_ok && (count_next != '0))
                        begin
                            pressed_next = 1'b1;
                            axis_next    = 1'b0;
                            state_next   = S_START;
                        end
                        else
                        begin
                            pressed_next = 1'b0;
                            res_h_next   = '0;
                            res_v_next   = '0;
                            state_next   = S_LOAD;
                        end
                    end
                end
            end
            // load the average divide for the current axis
            S_START:
            begin
                quo_next   = {sum_sel, {(DIV_W-SUM_W){1'b0}}};
                rem_next   = '0;
                dvs_next   = {{(DIV_W-CNT_W){1'b0}}, count_reg};
                step_next  = STEP_W'(SUM_W);
                state_next = S_AVG;
            end
            S_AVG:
            begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                    state_next = S_PREP;
            end
            // average ready in quo_reg: pass through or start calibration divide
            S_PREP:
            begin
                if (ratio_sel == '0)
                begin
                    if (axis_reg)
                        res_v_next = {{(SCREEN_W-RAW_W){1'b0}}, quo_reg[RAW_W-1:0]};
                    else
                        res_h_next = {{(SCREEN_W-RAW_W){1'b0}}, quo_reg[RAW_W-1:0]};
                    if (axis_reg)
                        state_next = S_LOAD;
                    else
                    begin
                        axis_next  = 1'b1;
                        state_next = S_START;
                    end
                end
                else
                begin
                    quo_next   = num_mag;
                    rem_next   = '0;
                    dvs_next   = ratio_mag;
                    neg_next   = num[NUM_W-1] ^ ratio_sel[CFG_W-1];
                    step_next  = STEP_W'(DIV_W);
                    state_next = S_CAL;
                end
            end
            S_CAL:
            begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                    state_next = S_SAT;
            end
            S_SAT:
            begin
                if (axis_reg)
                begin
                    res_v_next = sat_val;
                    state_next = S_LOAD;
                end
                else
                begin
                    res_h_next = sat_val;
                    axis_next  = 1'b1;
                    state_next = S_START;
                end
            end
            // hand the result to the output register once it is free
            S_LOAD:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_v_reg, res_h_reg};
                    m_user_next  = pressed_reg;
                    sum_h_next   = '0;
                    sum_v_next   = '0;
                    count_next   = '0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and accumulation registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sum_h_reg   <= '0;
            sum_v_reg   <= '0;
            count_reg   <= '0;
            step_reg    <= '0;
            axis_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_h_reg   <= sum_h_next;
            sum_v_reg   <= sum_v_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            axis_reg    <= axis_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dvs_reg     <= dvs_next;
        neg_reg     <= neg_next;
        pressed_reg <= pressed_next;
        res_h_reg   <= res_h_next;
        res_v_reg   <= res_v_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Configuration port
    logic       cfg_wr;
    logic [1:0] cfg_idx;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_h_reg <= '0;
            ratio_h_reg  <= '0;
            offset_v_reg <= '0;
            ratio_v_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_OFFSET_H: offset_h_reg <= pwdata;
                REG_RATIO_H:  ratio_h_reg  <= pwdata;
                REG_OFFSET_V: offset_v_reg <= pwdata;
                REG_RATIO_V:  ratio_v_reg  <= pwdata;
                default:      offset_h_reg <= offset_h_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_OFFSET_H: prdata = offset_h_reg;
            REG_RATIO_H:  prdata = ratio_h_reg;
            REG_OFFSET_V: prdata = offset_v_reg;
            REG_RATIO_V:  prdata = ratio_v_reg;
            default:      prdata = '0;
        endcase
    end

    // Checks
    `TPAC_NEVER(a_count_limit, count_reg > CNT_W'(MAX_POINTS), "contact count above limit")
    `TPAC_ASSERT(a_rem_below_dvs, ((state_reg == S_AVG) || (state_reg == S_CAL)) |-> ((rem_reg < dvs_reg) && (step_reg != '0)), "divider remainder or step count out of range")
    `TPAC_ASSERT(a_result_from_load, $rose(m_valid_reg) |-> $past(state_reg == S_LOAD), "result appeared without a load")
    `TPAC_ASSERT(a_unpressed_zero, (m_valid_reg && (m_user_reg == '0)) |-> (m_data_reg == '0), "unpressed result carries coordinates")

endmodule
